// ----- rtl/core/bpf_pkg.sv -----
package bpf_pkg;

  localparam int CORDIC_STEPS = 16;

  localparam logic [28:0] ATAN_TAB [0:31] = '{
    29'd210828714, 29'd124459457, 29'd65760959, 29'd33381290, 29'd16755422,
    29'd8385879, 29'd4193963, 29'd2097109, 29'd1048571, 29'd524287,
    29'd262144, 29'd131072, 29'd65536, 29'd32768, 29'd16384, 29'd8192,
    29'd4096, 29'd2048, 29'd1024, 29'd512, 29'd256, 29'd128, 29'd64, 29'd32,
    29'd16, 29'd8, 29'd4, 29'd2, 29'd1, 29'd0, 29'd0, 29'd0
  };

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic [1:0]         first_index;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [1:0]         second_index;
  } bpf_in_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [15:0] heading;
    logic               valid_res;
  } bpf_out_t;

endpackage

// ----- rtl/core/bpf_cordic.sv -----
module bpf_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [30:0]        x_in,
  input  logic [30:0]        y_in,
  output logic signed [30:0] z_out
);
  import bpf_pkg::*;

  logic signed [33:0] x_r [CORDIC_STEPS];
  logic signed [33:0] y_r [CORDIC_STEPS];
  logic signed [30:0] z_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic signed [33:0] x_p, y_p, xs, ys, x_nxt, y_nxt;
    logic signed [30:0] z_p, z_nxt, a;

    if (i == 0) begin : g_first
      assign x_p = signed'({3'b000, x_in});
      assign y_p = signed'({3'b000, y_in});
      assign z_p = '0;
    end else begin : g_next
      assign x_p = x_r[i-1];
      assign y_p = y_r[i-1];
      assign z_p = z_r[i-1];
    end

    assign xs = x_p >>> i;
    assign ys = y_p >>> i;
    assign a  = signed'({2'b00, ATAN_TAB[i]});

    always_comb begin
      if (!y_p[33]) begin
        x_nxt = x_p + ys;
        y_nxt = y_p - xs;
        z_nxt = z_p + a;
      end else begin
        x_nxt = x_p - ys;
        y_nxt = y_p + xs;
        z_nxt = z_p - a;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign z_out = z_r[CORDIC_STEPS-1];

endmodule

// ----- rtl/core/bpf_div.sv -----
module bpf_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic [31:0] quo
);
  import bpf_pkg::*;

  logic [32:0] rem_r [32];
  logic [31:0] lo_r  [32];
  logic [31:0] q_r   [32];
  logic [32:0] den_r [32];

  for (genvar i = 0; i < 32; i++) begin : g_stage
    logic [32:0] rem_p, den_p, rem_nxt;
    logic [31:0] lo_p, q_p;
    logic [33:0] t, d;
    logic        qb;

    if (i == 0) begin : g_first
      assign rem_p = {1'b0, num[63:32]};
      assign lo_p  = num[31:0];
      assign q_p   = '0;
      assign den_p = den;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign lo_p  = lo_r[i-1];
      assign q_p   = q_r[i-1];
      assign den_p = den_r[i-1];
    end

    assign t  = {rem_p, lo_p[31]};
    assign d  = {1'b0, den_p};
    assign qb = (t >= d);
    always_comb begin
      if (qb) rem_nxt = 33'(t - d);
      else rem_nxt = t[32:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        lo_r[i]  <= {lo_p[30:0], 1'b0};
        q_r[i]   <= {q_p[30:0], qb};
        den_r[i] <= den_p;
      end
    end
  end

  assign quo = q_r[31];

endmodule

// ----- rtl/core/box_pose_from_two_corners.sv -----
// Box pose from two corners: takes a corner pair per transfer and returns one
// result per transfer, centre in Q16.16 and heading in radians times 4096.
// Fully pipelined: one pair can be taken every cycle while the output is not
// stalled. The pipe depth is set by the 32-stage square root followed by the
// 32-stage offset divider; the CORDIC stages run alongside. Any stall on the
// output holds the whole pipe.
module box_pose_from_two_corners (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpf_pkg::bpf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bpf_pkg::bpf_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import bpf_pkg::*;

  localparam logic [1:0] KIND_LONG  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_AC    = 2'd2;
  localparam logic [1:0] KIND_BD    = 2'd3;
  localparam logic       REG_WIDTH  = 1'b0;
  localparam logic       REG_LENGTH = 1'b1;
  localparam int         NCAR       = 68;
  localparam int         NVLD       = 71;
  localparam logic signed [30:0] ANG_PI      = 31'sd843314857;
  localparam logic signed [30:0] ANG_HALF_PI = 31'sd421657428;
  localparam logic signed [16:0] HEAD_MAX    = 17'sd19303;

  typedef struct packed {
    logic [1:0] rsh;
    logic [4:0] lsh;
  } shift_t;

  typedef struct packed {
    logic               ok;
    logic [1:0]         kind;
    logic               dxneg;
    logic               dyneg;
    logic               dzero;
    logic               czero;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        nx;
    logic [30:0]        ny;
    logic signed [32:0] h;
  } carry_t;

  function automatic shift_t norm_code(logic [32:0] m);
    shift_t s;
    logic [5:0] p;
    p = '0;
    s = '0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) p = 6'(i);
    end
    if (m != '0) begin
      if (p == 6'd32) s.rsh = 2'd2;
      else if (p == 6'd31) s.rsh = 2'd1;
      else s.lsh = 5'(6'd30 - p);
    end
    return s;
  endfunction

  function automatic logic [30:0] norm_apply(logic [32:0] v, shift_t s);
    logic [32:0] t;
    t = (v >> s.rsh) << s.lsh;
    return t[30:0];
  endfunction

  logic [31:0] box_width_r, box_length_r;
  logic        adv;
  logic        vld_r [NVLD];
  logic        out_valid_r;
  bpf_out_t    out_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r  <= 32'd159777;
      box_length_r <= 32'd397017;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  box_width_r  <= cfg_data;
        REG_LENGTH: box_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: ordering, pair kind, differences, midpoint
  logic signed [31:0] px, py, qx, qy;
  logic signed [32:0] dx, dy, sx, sy;
  logic [1:0]         lo_i, hi_i, kind;
  logic               supp;
  carry_t             s1_nxt, s1_r, s2_r, s3_r;
  logic [32:0]        ux, uy, s1_ux_r, s1_uy_r, s2_ux_r, s2_uy_r;
  shift_t             s2_sh_r, s2_csh_r;

  always_comb begin
    if (in_data.first_index <= in_data.second_index) begin
      lo_i = in_data.first_index;  hi_i = in_data.second_index;
      px = in_data.first_x;  py = in_data.first_y;
      qx = in_data.second_x; qy = in_data.second_y;
    end else begin
      lo_i = in_data.second_index; hi_i = in_data.first_index;
      px = in_data.second_x; py = in_data.second_y;
      qx = in_data.first_x;  qy = in_data.first_y;
    end
    supp = 1'b1;
    case ({lo_i, hi_i})
      4'b0001: kind = KIND_LONG;
      4'b0110: kind = KIND_SHORT;
      4'b0010: kind = KIND_AC;
      4'b0111: kind = KIND_BD;
      default: begin
        kind = KIND_LONG;
        supp = 1'b0;
      end
    endcase
    dx = 33'(qx) - 33'(px);
    dy = 33'(qy) - 33'(py);
    sx = 33'(qx) + 33'(px);
    sy = 33'(qy) + 33'(py);
    ux = dx[32] ? 33'(-dx) : dx;
    uy = dy[32] ? 33'(-dy) : dy;
    s1_nxt       = '0;
    s1_nxt.kind  = kind;
    s1_nxt.dxneg = dx[32];
    s1_nxt.dyneg = dy[32];
    s1_nxt.dzero = (dx == '0) && (dy == '0);
    s1_nxt.ok    = supp && !(!kind[1] && s1_nxt.dzero);
    s1_nxt.czero = (box_width_r == '0) && (box_length_r == '0);
    s1_nxt.cx    = sx[32:1];
    s1_nxt.cy    = sy[32:1];
  end

  logic [30:0] s3_nl_r, s3_nw_r;
  carry_t      s3_nxt;

  always_comb begin
    s3_nxt    = s2_r;
    s3_nxt.nx = norm_apply(s2_ux_r, s2_sh_r);
    s3_nxt.ny = norm_apply(s2_uy_r, s2_sh_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= s1_nxt;
      s1_ux_r  <= ux;
      s1_uy_r  <= uy;
      s2_r     <= s1_r;
      s2_ux_r  <= s1_ux_r;
      s2_uy_r  <= s1_uy_r;
      s2_sh_r  <= norm_code(s1_ux_r | s1_uy_r);
      s2_csh_r <= norm_code({1'b0, box_length_r | box_width_r});
      s3_r     <= s3_nxt;
      s3_nl_r  <= norm_apply({1'b0, box_length_r}, s2_csh_r);
      s3_nw_r  <= norm_apply({1'b0, box_width_r}, s2_csh_r);
    end
  end

  carry_t car_r [NCAR];
  carry_t car_h;

  // angles
  logic signed [30:0] z_ang, z_corr, angm_r, corr_r;
  logic signed [30:0] angm;

  bpf_cordic u_cordic_d (
    .clk(clk), .en(adv), .x_in(s3_r.nx), .y_in(s3_r.ny), .z_out(z_ang)
  );
  bpf_cordic u_cordic_c (
    .clk(clk), .en(adv), .x_in(s3_nl_r), .y_in(s3_nw_r), .z_out(z_corr)
  );

  always_comb begin
    angm = z_ang;
    if (car_r[CORDIC_STEPS-1].dxneg) angm = ANG_PI - angm;
    if (car_r[CORDIC_STEPS-1].dyneg) angm = -angm;
    if (car_r[CORDIC_STEPS-1].dzero) angm = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angm_r <= angm;
      corr_r <= car_r[CORDIC_STEPS-1].czero ? '0 : z_corr;
    end
  end

  logic signed [32:0] h_calc;
  always_comb begin
    case (car_r[CORDIC_STEPS].kind)
      KIND_LONG:  h_calc = 33'(angm_r);
      KIND_SHORT: h_calc = 33'(angm_r) - 33'(ANG_HALF_PI);
      KIND_AC:    h_calc = 33'(angm_r) - 33'(corr_r);
      KIND_BD:    h_calc = 33'(angm_r) + 33'(corr_r);
      default:    h_calc = '0;
    endcase
  end

  always_comb begin
    car_h   = car_r[CORDIC_STEPS];
    car_h.h = h_calc;
  end

  // carry line, stages 4 to 71
  for (genvar j = 0; j < NCAR; j++) begin : g_car
    always_ff @(posedge clk) begin
      if (adv) begin
        if (j == 0) car_r[j] <= s3_r;
        else if (j == CORDIC_STEPS + 1) car_r[j] <= car_h;
        else car_r[j] <= car_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  // square root of the normalized squares
  logic [61:0] sqx_r, sqy_r;
  logic [63:0] ssum_r;
  logic [32:0] sq_rem_r  [32];
  logic [31:0] sq_root_r [32];
  logic [63:0] sq_v_r    [32];

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r  <= s3_r.nx * s3_r.nx;
      sqy_r  <= s3_r.ny * s3_r.ny;
      ssum_r <= 64'(sqx_r) + 64'(sqy_r);
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    logic [32:0] rem_p, rem_nxt;
    logic [31:0] root_p;
    logic [63:0] v_p;
    logic [34:0] t, tr;
    logic        hit;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign v_p    = ssum_r;
    end else begin : g_next
      assign rem_p  = sq_rem_r[k-1];
      assign root_p = sq_root_r[k-1];
      assign v_p    = sq_v_r[k-1];
    end
    assign t   = {rem_p, v_p[63:62]};
    assign tr  = {1'b0, root_p, 2'b01};
    assign hit = (t >= tr);
    always_comb begin
      if (hit) rem_nxt = 33'(t - tr);
      else rem_nxt = t[32:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[k]  <= rem_nxt;
        sq_root_r[k] <= {root_p[30:0], hit};
        sq_v_r[k]    <= {v_p[61:0], 2'b00};
      end
    end
  end

  // offsets: (u * s + mag) / (2 * mag)
  logic [31:0] mag_r, side_s;
  logic [62:0] prodx_r, prody_r;
  logic [63:0] numx_r, numy_r;
  logic [32:0] den_r;
  logic [31:0] offx, offy;

  assign side_s = (car_r[33].kind == KIND_LONG) ? box_width_r : box_length_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prodx_r <= car_r[33].ny * side_s;
      prody_r <= car_r[33].nx * side_s;
      mag_r   <= sq_root_r[31];
      numx_r  <= 64'(prodx_r) + 64'(mag_r);
      numy_r  <= 64'(prody_r) + 64'(mag_r);
      den_r   <= {mag_r, 1'b0};
    end
  end

  bpf_div u_div_x (.clk(clk), .en(adv), .num(numx_r), .den(den_r), .quo(offx));
  bpf_div u_div_y (.clk(clk), .en(adv), .num(numy_r), .den(den_r), .quo(offy));

  // output stage
  carry_t             fin;
  logic signed [33:0] ex, ey, ox, oy;
  logic signed [32:0] hs;
  logic signed [16:0] hr;
  bpf_out_t           out_nxt;

  assign fin = car_r[NCAR-1];

  always_comb begin
    ox = '0;
    oy = '0;
    if (!fin.kind[1]) begin
      ox = fin.dyneg ? signed'({2'b00, offx}) : -signed'({2'b00, offx});
      oy = fin.dxneg ? -signed'({2'b00, offy}) : signed'({2'b00, offy});
    end
    ex = 34'(fin.cx) + ox;
    ey = 34'(fin.cy) + oy;
    hs = fin.h + 33'sd32768;
    hr = hs[32:16];
    out_nxt = '0;
    if (fin.ok) begin
      if (ex > 34'sd2147483647) out_nxt.center_x = 32'sh7fffffff;
      else if (ex < -34'sd2147483648) out_nxt.center_x = 32'sh80000000;
      else out_nxt.center_x = ex[31:0];
      if (ey > 34'sd2147483647) out_nxt.center_y = 32'sh7fffffff;
      else if (ey < -34'sd2147483648) out_nxt.center_y = 32'sh80000000;
      else out_nxt.center_y = ey[31:0];
      if (hr > HEAD_MAX) out_nxt.heading = HEAD_MAX[15:0];
      else if (hr < -HEAD_MAX) out_nxt.heading = 16'(-HEAD_MAX);
      else out_nxt.heading = hr[15:0];
      out_nxt.valid_res = 1'b1;
    end
  end

  for (genvar v = 0; v < NVLD; v++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[v] <= 1'b0;
      else if (adv) begin
        if (v == 0) vld_r[v] <= in_valid;
        else vld_r[v] <= vld_r[(v == 0) ? 0 : v-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vld_r[NVLD-1];
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NVLD-1] && adv |=> out_valid)
    else $error("pipeline lost a result");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.center_x == 0 && out_data.center_y == 0 && out_data.heading == 0)
    else $error("rejected pair with nonzero result");

  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.heading <= 16'sd19303 && out_data.heading >= -16'sd19303)
    else $error("heading beyond limit");

endmodule

// ----- dv/box_pose_from_two_corners_tb.sv -----
module box_pose_from_two_corners_tb;
  import bpf_pkg::*;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;
  localparam longint PI_Q28      = 843314857;
  localparam longint HALF_PI_Q28 = 421657428;
  localparam longint HEAD_MAX    = 19303;
  localparam int     PIPE_DEPTH  = 72;

  typedef enum int {PAIR_LONG, PAIR_SHORT, PAIR_DIAG_AC, PAIR_DIAG_BD, PAIR_NONE} pair_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bpf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bpf_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  box_pose_from_two_corners dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] width_q = 32'd159777;
  logic [31:0] length_q = 32'd397017;
  bpf_out_t pose_queue[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void scale_pair(inout longint unsigned a, inout longint unsigned b);
    longint unsigned m;
    m = (a > b) ? a : b;
    if (m == 0) return;
    while (m >= 64'h8000_0000) begin
      a = a >> 1; b = b >> 1; m = m >> 1;
    end
    while (m < 64'h4000_0000) begin
      a = a << 1; b = b << 1; m = m << 1;
    end
  endfunction

  function automatic longint vector_angle(longint unsigned ux, longint unsigned uy);
    longint x, y, z, xs, ys;
    x = ux; y = uy; z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 2147483647;
    if (v < -64'sd2147483648) return -2147483648;
    return v;
  endfunction

  function automatic bpf_out_t pose_of(bpf_in_t c);
    bpf_out_t r;
    longint px, py, qx, qy, dx, dy, cx, cy, ang, h, corr;
    longint unsigned ux, uy, s, mag, offx, offy, lx, wy;
    int lo, hi;
    pair_e kind;
    r = '0;
    ang = 0;
    if (c.first_index <= c.second_index) begin
      lo = c.first_index; hi = c.second_index;
      px = c.first_x; py = c.first_y; qx = c.second_x; qy = c.second_y;
    end else begin
      lo = c.second_index; hi = c.first_index;
      px = c.second_x; py = c.second_y; qx = c.first_x; qy = c.first_y;
    end
    if (lo == 0 && hi == 1) kind = PAIR_LONG;
    else if (lo == 1 && hi == 2) kind = PAIR_SHORT;
    else if (lo == 0 && hi == 2) kind = PAIR_DIAG_AC;
    else if (lo == 1 && hi == 3) kind = PAIR_DIAG_BD;
    else kind = PAIR_NONE;
    if (kind == PAIR_NONE) return r;
    dx = qx - px; dy = qy - py;
    if ((kind == PAIR_LONG || kind == PAIR_SHORT) && dx == 0 && dy == 0) return r;
    cx = floor_shr(px + qx, 1);
    cy = floor_shr(py + qy, 1);
    if (dx != 0 || dy != 0) begin
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      scale_pair(ux, uy);
      ang = vector_angle(ux, uy);
      if (dx < 0) ang = PI_Q28 - ang;
      if (dy < 0) ang = -ang;
      if (kind == PAIR_LONG || kind == PAIR_SHORT) begin
        s = (kind == PAIR_LONG) ? width_q : length_q;
        mag = root_floor(ux * ux + uy * uy);
        offx = (uy * s + mag) / (2 * mag);
        offy = (ux * s + mag) / (2 * mag);
        cx += (dy < 0) ? longint'(offx) : -longint'(offx);
        cy += (dx < 0) ? -longint'(offy) : longint'(offy);
      end
    end
    case (kind)
      PAIR_LONG:  h = ang;
      PAIR_SHORT: h = ang - HALF_PI_Q28;
      default: begin
        lx = length_q; wy = width_q; corr = 0;
        if (lx != 0 || wy != 0) begin
          scale_pair(lx, wy);
          corr = vector_angle(lx, wy);
        end
        h = (kind == PAIR_DIAG_AC) ? ang - corr : ang + corr;
      end
    endcase
    h = floor_shr(h + 32768, 16);
    if (h > HEAD_MAX) h = HEAD_MAX;
    if (h < -HEAD_MAX) h = -HEAD_MAX;
    r.center_x = 32'(clip32(cx));
    r.center_y = 32'(clip32(cy));
    r.heading = 16'(h);
    r.valid_res = 1'b1;
    return r;
  endfunction

  typedef struct {
    bpf_in_t  corners;
    bit       typed;
    bpf_out_t pose;
  } vector_t;

  function automatic bpf_in_t pair(int fx, int fy, int fi, int sx, int sy, int si);
    bpf_in_t c;
    c.first_x = fx; c.first_y = fy; c.first_index = 2'(fi);
    c.second_x = sx; c.second_y = sy; c.second_index = 2'(si);
    return c;
  endfunction

  task automatic send(bpf_in_t c, bit typed, bpf_out_t pose);
    pose_queue.push_back(typed ? pose : pose_of(c));
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_in(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pose_queue.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) width_q = v; else length_q = v;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endcase
  endfunction

  function automatic bpf_in_t rand_pair();
    bpf_in_t c;
    int k;
    c.first_x = rand_coord(); c.first_y = rand_coord();
    c.first_index = 2'($urandom()); c.second_index = 2'($urandom());
    k = $urandom_range(0, 9);
    if (k < 6) begin
      c.second_x = c.first_x + ($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      c.second_y = c.first_y + ($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    end else if (k == 6) begin
      c.second_x = c.first_x; c.second_y = c.first_y;
    end else begin
      c.second_x = rand_coord(); c.second_y = rand_coord();
    end
    if (k < 8 && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: begin c.first_index = 2'd0; c.second_index = 2'd1; end
        1: begin c.first_index = 2'd1; c.second_index = 2'd2; end
        2: begin c.first_index = 2'd0; c.second_index = 2'd2; end
        default: begin c.first_index = 2'd1; c.second_index = 2'd3; end
      endcase
      if ($urandom_range(0, 1)) begin
        c.first_index = c.first_index ^ c.second_index;
        c.second_index = c.first_index ^ c.second_index;
        c.first_index = c.first_index ^ c.second_index;
      end
    end
    return c;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        send(rand_pair(), 1'b0, '0);
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) idle_in($urandom_range(1, 6));
    end
  endtask

  bpf_out_t zero_pose;
  vector_t directed[$];

  initial begin
    zero_pose = '0;
    directed = '{
      '{pair(0, 0, 0, 0, 0, 0), 1'b1, zero_pose},
      '{pair(100, 5, 0, -7, 9, 3), 1'b1, zero_pose},
      '{pair(100, 5, 3, -7, 9, 2), 1'b1, zero_pose},
      '{pair(65536, 65536, 0, 65536, 65536, 1), 1'b1, zero_pose},
      '{pair(-3, 4, 2, -3, 4, 1), 1'b1, zero_pose},
      '{pair(65536, 0, 0, 65536, 0, 2), 1'b0, zero_pose},
      '{pair(0, 0, 0, 65536, 0, 1), 1'b0, zero_pose},
      '{pair(65536, 0, 1, 0, 0, 0), 1'b0, zero_pose},
      '{pair(0, 0, 1, 0, 65536, 2), 1'b0, zero_pose},
      '{pair(0, 0, 2, -65536, 0, 1), 1'b0, zero_pose},
      '{pair(0, 0, 0, 131072, 65536, 2), 1'b0, zero_pose},
      '{pair(0, 0, 3, -131072, -65536, 1), 1'b0, zero_pose},
      '{pair(32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, 1), 1'b0, zero_pose},
      '{pair(32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 1), 1'b0, zero_pose},
      '{pair(32'sh7fffffff, 0, 1, 32'sh7fffffff, 65536, 2), 1'b0, zero_pose},
      '{pair(32'sh80000000, 0, 2, 32'sh80000000, -65536, 0), 1'b0, zero_pose},
      '{pair(0, 0, 0, -65536, -1, 1), 1'b0, zero_pose},
      '{pair(0, 0, 1, -65536, 1, 3), 1'b0, zero_pose},
      '{pair(5, -5, 0, 5, -4, 1), 1'b0, zero_pose}
    };
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send(directed[i].corners, directed[i].typed, directed[i].pose);
    random_phase(400);
    drain();
    write_reg(CFG_WIDTH, 32'd1);
    write_reg(CFG_LENGTH, 32'hffffffff);
    foreach (directed[i]) send(directed[i].corners, 1'b0, zero_pose);
    random_phase(300);
    hold_off = 1'b1;
    random_phase(200);
    hold_off = 1'b0;
    drain();
    write_reg(CFG_WIDTH, 32'hffffffff);
    write_reg(CFG_LENGTH, 32'd1);
    random_phase(300);
    drain();
    write_reg(CFG_WIDTH, 32'd0);
    write_reg(CFG_LENGTH, 32'd0);
    send(pair(7, 7, 0, 7, 7, 2), 1'b0, zero_pose);
    send(pair(7, 7, 3, 9, 7, 1), 1'b0, zero_pose);
    random_phase(200);
    drain();
    write_reg(CFG_WIDTH, $urandom());
    write_reg(CFG_LENGTH, $urandom());
    random_phase(400);
    drain();
    write_reg(CFG_WIDTH, 32'd159777);
    write_reg(CFG_LENGTH, 32'd397017);
    random_phase(200);
    drain();
    stim_done = 1'b1;
  end

  // receiver: own stall pattern, one long hold-off on request
  initial begin
    int cyc;
    bit held;
    cyc = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_off && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (cyc % 512 < 128) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    bpf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, out_data);
        errors++;
      end else begin
        want = pose_queue.pop_front();
        if (out_data.center_x !== want.center_x) begin
          $display("%0t: center_x exp %0d got %0d", $time, want.center_x, out_data.center_x);
          errors++;
        end
        if (out_data.center_y !== want.center_y) begin
          $display("%0t: center_y exp %0d got %0d", $time, want.center_y, out_data.center_y);
          errors++;
        end
        if (out_data.heading !== want.heading) begin
          $display("%0t: heading exp %0d got %0d", $time, want.heading, out_data.heading);
          errors++;
        end
        if (out_data.valid_res !== want.valid_res) begin
          $display("%0t: valid_res exp %0b got %0b", $time, want.valid_res,
                   out_data.valid_res);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && pose_queue.size() == 0) begin
      $display("box_pose_from_two_corners_tb passed");
    end else begin
      $display("box_pose_from_two_corners_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("box_pose_from_two_corners_tb failed");
    $finish;
  end

endmodule

// ----- box_pose_from_two_corners.f -----
rtl/core/bpf_pkg.sv
rtl/core/bpf_cordic.sv
rtl/core/bpf_div.sv
rtl/core/box_pose_from_two_corners.sv
dv/box_pose_from_two_corners_tb.sv
